>>> rtl/core/aarm_pkg.sv
// Shared types and constants of the axis-angle rotation matrix unit.
`timescale 1ns / 1ps

package aarm_pkg;

  // Angle handling, Q16.16 degrees
  localparam logic [32:0] FULL_TURN  = 33'd23592960;    // 360 deg
  localparam logic [32:0] QUARTER    = 33'd5898240;     // 90 deg
  localparam logic [32:0] HALF_TURN  = 33'd11796480;    // 180 deg
  localparam logic [32:0] THREE_QTR  = 33'd17694720;    // 270 deg
  localparam logic [32:0] MOD_OFFSET = 33'd2170552320;  // 92 full turns
  localparam logic [26:0] DEG_TO_RAD = 27'd74961321;    // pi/180 * 2^32

  // CORDIC, Q2.30
  localparam logic signed [33:0] GAIN_INV = 34'sd652032874;
  localparam logic signed [34:0] Q30_ONE  = 35'sd1073741824;

  // Squared length, Q4.28
  localparam logic signed [32:0] UNIT_SQ = 33'sd268435456;

  // Output format
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
  localparam logic [15:0] TOL_RESET = 16'd32;

  localparam logic [29:0] ATAN_Q30 [32] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
    30'd127, 30'd63, 30'd31, 30'd15, 30'd7, 30'd3, 30'd1, 30'd0, 30'd0
  };

  // Per-word axis data that rides along the sqrt and divider cells
  typedef struct packed {
    logic               vld;
    logic               zero;
    logic               norm;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic [31:0]        mag2;
  } axis_info_t;

  // CORDIC rotation state plus quadrant fold flags
  typedef struct packed {
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic signed [33:0] cz;
    logic               neg_s;
    logic               neg_c;
  } cordic_t;

endpackage

>>> rtl/core/axis_angle_rotation_matrix_unit.sv
// Top level: axis-angle to 3x3 rotation matrix, fully pipelined.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+------------------------------------------
//  cfg     | in  | cfg_valid / cfg_ready | cfg_wdata: unit_tolerance (16b)
//  in      | in  | in_tvalid / in_tready | in_tdata: axis_x, axis_y, axis_z, angle_deg
//  out     | out | out_tvalid/out_tready | out_tdata: m00..m22, out_tuser: zero_axis
//
// One word accepted per cycle while the pipeline is not frozen. The latency from accept to
// out_tvalid is set by the 32-cell square root chain and the FRAC_BITS + 1 cell
// normalization divider; the angle path (modulo, CORDIC) runs alongside in a
// shorter chain that is delayed to meet it. Reset empties the pipeline and sets
// unit_tolerance to 32. The pipeline freezes only when its last stage holds a
// word and the output register is full and not taken.
`timescale 1ns / 1ps

module axis_angle_rotation_matrix_unit #(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int FRAC_BITS         = 14
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_wdata,   // unit_tolerance
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [79:0]  in_tdata,    // axis_x, axis_y, axis_z, angle_deg
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic         out_tuser    // zero_axis
);

  localparam int NITER = (CORDIC_ITERATIONS < 32) ? CORDIC_ITERATIONS : 32;
  localparam int DLY   = 27 + FRAC_BITS - NITER;
  localparam int UW    = FRAC_BITS + 3;
  localparam int NW    = FRAC_BITS + 33;
  localparam int QW    = FRAC_BITS + 1;
  localparam int PW    = 2 * UW;
  localparam int TPW   = UW + 36;
  localparam int RW    = 37;
  localparam int MW    = 38;
  localparam logic signed [PW-1:0]  HALF_P = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [TPW-1:0] HALF_T = TPW'(1) << (FRAC_BITS - 1);
  localparam logic signed [MW-1:0]  HALF_M = MW'(1) << 15;

  logic en;
  logic last_v;

  // ---------------- config register ----------------
  logic [15:0] tol_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= aarm_pkg::TOL_RESET;
    end else if (cfg_valid) begin
      tol_r <= cfg_wdata;
    end
  end

  // ---------------- flow control ----------------
  logic         out_valid_r;
  logic [143:0] out_data_r;
  logic         out_zero_r;

  assign en        = !(last_v && out_valid_r && !out_tready);
  assign in_tready = en;

  // ---------------- input register ----------------
  logic               s0_v_r;
  logic signed [15:0] s0_ax_r;
  logic signed [15:0] s0_ay_r;
  logic signed [15:0] s0_az_r;
  logic signed [31:0] s0_ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_ax_r  <= in_tdata[15:0];
      s0_ay_r  <= in_tdata[31:16];
      s0_az_r  <= in_tdata[47:32];
      s0_ang_r <= in_tdata[79:48];
    end
  end

  // ---------------- axis: squares ----------------
  logic               a1_v_r;
  logic signed [15:0] a1_ax_r;
  logic signed [15:0] a1_ay_r;
  logic signed [15:0] a1_az_r;
  logic [31:0]        a1_sqx_r;
  logic [31:0]        a1_sqy_r;
  logic [31:0]        a1_sqz_r;
  logic signed [31:0] sqx;
  logic signed [31:0] sqy;
  logic signed [31:0] sqz;

  assign sqx = 32'(s0_ax_r * s0_ax_r);
  assign sqy = 32'(s0_ay_r * s0_ay_r);
  assign sqz = 32'(s0_az_r * s0_az_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_v_r <= 1'b0;
    end else if (en) begin
      a1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_ax_r  <= s0_ax_r;
      a1_ay_r  <= s0_ay_r;
      a1_az_r  <= s0_az_r;
      a1_sqx_r <= sqx;
      a1_sqy_r <= sqy;
      a1_sqz_r <= sqz;
    end
  end

  // ---------------- axis: length, tolerance check ----------------
  aarm_pkg::axis_info_t a2_info_r;
  aarm_pkg::axis_info_t a2_info_nxt;
  logic [31:0]          mag2;
  logic signed [32:0]   dev;
  logic [32:0]          abs_dev;

  always_comb begin
    mag2    = a1_sqx_r + a1_sqy_r + a1_sqz_r;
    dev     = $signed({1'b0, mag2}) - aarm_pkg::UNIT_SQ;
    abs_dev = dev[32] ? 33'(-dev) : 33'(dev);
    a2_info_nxt.vld  = a1_v_r;
    a2_info_nxt.zero = (mag2 == 32'd0);
    a2_info_nxt.norm = (abs_dev > {17'd0, tol_r});
    a2_info_nxt.ax   = a1_ax_r;
    a2_info_nxt.ay   = a1_ay_r;
    a2_info_nxt.az   = a1_az_r;
    a2_info_nxt.mag2 = mag2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a2_info_r.vld <= 1'b0;
    end else if (en) begin
      a2_info_r <= a2_info_nxt;
    end
  end

  // ---------------- axis: square root chain ----------------
  aarm_pkg::axis_info_t sq_info [33];
  logic [33:0]          sq_rem  [33];
  logic [31:0]          sq_root [33];

  assign sq_info[0] = a2_info_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < 32; k++) begin : g_sqrt
    aarm_sqrt_cell #(.STEP(k)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .info_i (sq_info[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .info_o (sq_info[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1])
    );
  end

  // ---------------- axis: divider numerators ----------------
  aarm_pkg::axis_info_t dv_info [QW+1];
  logic [31:0]          dv_len  [QW+1];
  logic [NW-1:0]        dv_rem  [QW+1][3];
  logic [QW-1:0]        dv_q    [QW+1][3];

  aarm_pkg::axis_info_t pr_info_r;
  logic [31:0]          pr_len_r;
  logic [NW-1:0]        pr_rem_r [3];
  logic [NW-1:0]        pr_rem_nxt [3];
  logic [15:0]          pr_mag [3];

  always_comb begin
    pr_mag[0] = sq_info[32].ax[15] ? 16'(-sq_info[32].ax) : 16'(sq_info[32].ax);
    pr_mag[1] = sq_info[32].ay[15] ? 16'(-sq_info[32].ay) : 16'(sq_info[32].ay);
    pr_mag[2] = sq_info[32].az[15] ? 16'(-sq_info[32].az) : 16'(sq_info[32].az);
    for (int a = 0; a < 3; a++) begin
      pr_rem_nxt[a] = (NW'(pr_mag[a]) << (FRAC_BITS + 16)) + NW'(sq_root[32] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_info_r.vld <= 1'b0;
    end else if (en) begin
      pr_info_r <= sq_info[32];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr_len_r <= sq_root[32];
      pr_rem_r <= pr_rem_nxt;
    end
  end

  assign dv_info[0] = pr_info_r;
  assign dv_len[0]  = pr_len_r;
  for (genvar a = 0; a < 3; a++) begin : g_dv0
    assign dv_rem[0][a] = pr_rem_r[a];
    assign dv_q[0][a]   = '0;
  end

  // ---------------- axis: divider chain ----------------
  for (genvar j = 0; j < QW; j++) begin : g_div
    aarm_div_cell #(.FRAC_BITS(FRAC_BITS), .BIT(QW - 1 - j)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .info_i (dv_info[j]),
      .len_i  (dv_len[j]),
      .rem_i  (dv_rem[j]),
      .q_i    (dv_q[j]),
      .info_o (dv_info[j+1]),
      .len_o  (dv_len[j+1]),
      .rem_o  (dv_rem[j+1]),
      .q_o    (dv_q[j+1])
    );
  end

  // ---------------- axis: unit components ----------------
  // tag stages: 0 unit, 1..5 product/sum stages
  logic               tag_v_r [6];
  logic               tag_z_r [6];
  logic signed [UW-1:0] u_r   [3];
  logic signed [UW-1:0] u_nxt [3];
  logic [UW-1:0]      raw_mag [3];
  logic [15:0]        u_mag   [3];
  logic               u_neg   [3];
  aarm_pkg::axis_info_t fin;

  assign fin = dv_info[QW];

  always_comb begin
    u_neg[0] = fin.ax[15];
    u_neg[1] = fin.ay[15];
    u_neg[2] = fin.az[15];
    u_mag[0] = fin.ax[15] ? 16'(-fin.ax) : 16'(fin.ax);
    u_mag[1] = fin.ay[15] ? 16'(-fin.ay) : 16'(fin.ay);
    u_mag[2] = fin.az[15] ? 16'(-fin.az) : 16'(fin.az);
  end

  // unnormalized path: rescale Q14 to FRAC_BITS
  if (FRAC_BITS >= 14) begin : g_up
    for (genvar a = 0; a < 3; a++) begin : g_ax
      assign raw_mag[a] = UW'(u_mag[a]) << (FRAC_BITS - 14);
    end
  end else begin : g_dn
    for (genvar a = 0; a < 3; a++) begin : g_ax
      assign raw_mag[a] =
        UW'((u_mag[a] + (16'd1 << (13 - FRAC_BITS))) >> (14 - FRAC_BITS));
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (fin.norm) begin
        u_nxt[a] = u_neg[a] ? -$signed(UW'(dv_q[QW][a])) : $signed(UW'(dv_q[QW][a]));
      end else begin
        u_nxt[a] = u_neg[a] ? -$signed(raw_mag[a]) : $signed(raw_mag[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) tag_v_r[i] <= 1'b0;
    end else if (en) begin
      tag_v_r[0] <= fin.vld;
      for (int i = 1; i < 6; i++) tag_v_r[i] <= tag_v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_z_r[0] <= fin.zero;
      for (int i = 1; i < 6; i++) tag_z_r[i] <= tag_z_r[i-1];
      u_r <= u_nxt;
    end
  end

  // ---------------- angle: delay to meet the axis path ----------------
  logic signed [31:0] dly_r [DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      dly_r[0] <= s0_ang_r;
      for (int i = 1; i < DLY; i++) dly_r[i] <= dly_r[i-1];
    end
  end

  // ---------------- angle: modulo 360 by restoring steps ----------------
  logic [32:0] mod_v0;
  logic [32:0] mod_r [8];

  assign mod_v0 = dly_r[DLY-1][31] ? 33'(dly_r[DLY-1]) + aarm_pkg::MOD_OFFSET
                                   : 33'(dly_r[DLY-1]);

  for (genvar j = 0; j < 8; j++) begin : g_mod
    localparam logic [32:0] CAND = aarm_pkg::FULL_TURN << (7 - j);
    logic [32:0] vin;
    if (j == 0) begin : g_first
      assign vin = mod_v0;
    end else begin : g_next
      assign vin = mod_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (en) mod_r[j] <= (vin >= CAND) ? vin - CAND : vin;
    end
  end

  // ---------------- angle: quadrant fold ----------------
  logic [22:0] fold_theta_r;
  logic [22:0] fold_theta_nxt;
  logic        fold_ns_r;
  logic        fold_ns_nxt;
  logic        fold_nc_r;
  logic        fold_nc_nxt;

  always_comb begin
    fold_theta_nxt = 23'(mod_r[7]);
    fold_ns_nxt    = 1'b0;
    fold_nc_nxt    = 1'b0;
    if (mod_r[7] <= aarm_pkg::QUARTER) begin
      fold_theta_nxt = 23'(mod_r[7]);
    end else if (mod_r[7] <= aarm_pkg::HALF_TURN) begin
      fold_theta_nxt = 23'(aarm_pkg::HALF_TURN - mod_r[7]);
      fold_nc_nxt    = 1'b1;
    end else if (mod_r[7] <= aarm_pkg::THREE_QTR) begin
      fold_theta_nxt = 23'(mod_r[7] - aarm_pkg::HALF_TURN);
      fold_ns_nxt    = 1'b1;
      fold_nc_nxt    = 1'b1;
    end else begin
      fold_theta_nxt = 23'(aarm_pkg::FULL_TURN - mod_r[7]);
      fold_ns_nxt    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fold_theta_r <= fold_theta_nxt;
      fold_ns_r    <= fold_ns_nxt;
      fold_nc_r    <= fold_nc_nxt;
    end
  end

  // ---------------- angle: degrees to radians ----------------
  logic [49:0] rad_p_r;
  logic        rad_ns_r;
  logic        rad_nc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rad_p_r  <= 50'(fold_theta_r) * 50'(aarm_pkg::DEG_TO_RAD);
      rad_ns_r <= fold_ns_r;
      rad_nc_r <= fold_nc_r;
    end
  end

  aarm_pkg::cordic_t cord [NITER+1];
  aarm_pkg::cordic_t cord0_r;
  aarm_pkg::cordic_t cord0_nxt;

  always_comb begin
    cord0_nxt.cx    = aarm_pkg::GAIN_INV;
    cord0_nxt.cy    = '0;
    cord0_nxt.cz    = $signed(34'((rad_p_r + 50'd131072) >> 18));
    cord0_nxt.neg_s = rad_ns_r;
    cord0_nxt.neg_c = rad_nc_r;
  end

  always_ff @(posedge clk) begin
    if (en) cord0_r <= cord0_nxt;
  end

  assign cord[0] = cord0_r;

  // ---------------- angle: CORDIC chain ----------------
  for (genvar k = 0; k < NITER; k++) begin : g_cordic
    aarm_cordic_cell #(.STEP(k)) u_cell (
      .clk (clk),
      .en  (en),
      .c_i (cord[k]),
      .c_o (cord[k+1])
    );
  end

  // ---------------- c, s, t ----------------
  logic signed [34:0] cst_c_r;
  logic signed [34:0] cst_s_r;
  logic signed [34:0] cst_t_r;
  logic signed [34:0] c_nxt;
  logic signed [34:0] s_nxt;

  always_comb begin
    c_nxt = cord[NITER].neg_c ? -35'(cord[NITER].cx) : 35'(cord[NITER].cx);
    s_nxt = cord[NITER].neg_s ? -35'(cord[NITER].cy) : 35'(cord[NITER].cy);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cst_c_r <= c_nxt;
      cst_s_r <= s_nxt;
      cst_t_r <= aarm_pkg::Q30_ONE - c_nxt;
    end
  end

  // ---------------- M1: axis products ----------------
  // order: xx, yy, zz, xy, xz, yz
  logic signed [PW-1:0] m1_p_r [6];
  logic signed [UW-1:0] m1_u_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      m1_p_r[0] <= PW'(u_r[0]) * PW'(u_r[0]);
      m1_p_r[1] <= PW'(u_r[1]) * PW'(u_r[1]);
      m1_p_r[2] <= PW'(u_r[2]) * PW'(u_r[2]);
      m1_p_r[3] <= PW'(u_r[0]) * PW'(u_r[1]);
      m1_p_r[4] <= PW'(u_r[0]) * PW'(u_r[2]);
      m1_p_r[5] <= PW'(u_r[1]) * PW'(u_r[2]);
      m1_u_r    <= u_r;
    end
  end

  // ---------------- M2: round products ----------------
  logic signed [UW:0]   m2_pp_r [6];
  logic signed [UW-1:0] m2_u_r  [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        m2_pp_r[k] <= (UW+1)'((m1_p_r[k] + HALF_P) >>> FRAC_BITS);
      end
      m2_u_r <= m1_u_r;
    end
  end

  // ---------------- M3: t and s products ----------------
  logic signed [TPW-1:0] m3_tp_r [6];
  logic signed [TPW-1:0] m3_sp_r [3];
  logic signed [34:0]    m3_c_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        m3_tp_r[k] <= TPW'(cst_t_r) * TPW'(m2_pp_r[k]);
      end
      for (int a = 0; a < 3; a++) begin
        m3_sp_r[a] <= TPW'(cst_s_r) * TPW'(m2_u_r[a]);
      end
      m3_c_r <= cst_c_r;
    end
  end

  // ---------------- M4: round and sum ----------------
  logic signed [RW-1:0] tr [6];
  logic signed [RW-1:0] sr [3];
  logic signed [MW-1:0] m4_sum_nxt [9];
  logic signed [MW-1:0] m4_sum_r   [9];
  logic signed [MW-1:0] cext;

  always_comb begin
    for (int k = 0; k < 6; k++) tr[k] = RW'((m3_tp_r[k] + HALF_T) >>> FRAC_BITS);
    for (int a = 0; a < 3; a++) sr[a] = RW'((m3_sp_r[a] + HALF_T) >>> FRAC_BITS);
    cext = MW'(m3_c_r);
    m4_sum_nxt[0] = MW'(tr[0]) + cext;
    m4_sum_nxt[1] = MW'(tr[3]) + MW'(sr[2]);
    m4_sum_nxt[2] = MW'(tr[4]) - MW'(sr[1]);
    m4_sum_nxt[3] = MW'(tr[3]) - MW'(sr[2]);
    m4_sum_nxt[4] = MW'(tr[1]) + cext;
    m4_sum_nxt[5] = MW'(tr[5]) + MW'(sr[0]);
    m4_sum_nxt[6] = MW'(tr[4]) + MW'(sr[1]);
    m4_sum_nxt[7] = MW'(tr[5]) - MW'(sr[0]);
    m4_sum_nxt[8] = MW'(tr[2]) + cext;
  end

  always_ff @(posedge clk) begin
    if (en) m4_sum_r <= m4_sum_nxt;
  end

  // ---------------- M5: Q14 rounding, saturation, zero-axis identity ----------------
  logic signed [15:0]   m5_m_r   [9];
  logic signed [15:0]   m5_m_nxt [9];
  logic signed [MW-1:0] rq [9];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      rq[k] = (m4_sum_r[k] + HALF_M) >>> 16;
      if (tag_z_r[4]) begin
        m5_m_nxt[k] = (k % 4 == 0) ? aarm_pkg::ONE_Q14 : 16'sd0;
      end else if (rq[k] > MW'(aarm_pkg::ONE_Q14)) begin
        m5_m_nxt[k] = aarm_pkg::ONE_Q14;
      end else if (rq[k] < -MW'(aarm_pkg::ONE_Q14)) begin
        m5_m_nxt[k] = -aarm_pkg::ONE_Q14;
      end else begin
        m5_m_nxt[k] = 16'(rq[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) m5_m_r <= m5_m_nxt;
  end

  assign last_v = tag_v_r[5];

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= last_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_data_r <= {m5_m_r[8], m5_m_r[7], m5_m_r[6], m5_m_r[5], m5_m_r[4],
                     m5_m_r[3], m5_m_r[2], m5_m_r[1], m5_m_r[0]};
      out_zero_r <= tag_z_r[5];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_zero_r;

endmodule

>>> rtl/core/aarm_cordic_cell.sv
// One rotation-mode CORDIC iteration with its output register.
`timescale 1ns / 1ps

module aarm_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              en,
  input  aarm_pkg::cordic_t c_i,
  output aarm_pkg::cordic_t c_o
);

  localparam logic signed [33:0] ANG = 34'(aarm_pkg::ATAN_Q30[STEP]);

  aarm_pkg::cordic_t c_r;
  aarm_pkg::cordic_t c_nxt;
  logic signed [33:0] dx;
  logic signed [33:0] dy;

  // floor shifts, direction from sign of residual angle
  always_comb begin
    dx    = c_i.cy >>> STEP;
    dy    = c_i.cx >>> STEP;
    c_nxt = c_i;
    if (!c_i.cz[33]) begin
      c_nxt.cx = c_i.cx - dx;
      c_nxt.cy = c_i.cy + dy;
      c_nxt.cz = c_i.cz - ANG;
    end else begin
      c_nxt.cx = c_i.cx + dx;
      c_nxt.cy = c_i.cy - dy;
      c_nxt.cz = c_i.cz + ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (en) c_r <= c_nxt;
  end

  assign c_o = c_r;

endmodule

>>> rtl/core/aarm_sqrt_cell.sv
// One digit step of the integer square root of mag2 * 2^32.
`timescale 1ns / 1ps

module aarm_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  aarm_pkg::axis_info_t info_i,
  input  logic [33:0]          rem_i,
  input  logic [31:0]          root_i,
  output aarm_pkg::axis_info_t info_o,
  output logic [33:0]          rem_o,
  output logic [31:0]          root_o
);

  localparam int PAIR = 31 - STEP;

  aarm_pkg::axis_info_t info_r;
  logic [33:0] rem_r;
  logic [33:0] rem_nxt;
  logic [31:0] root_r;
  logic [31:0] root_nxt;
  logic [1:0]  pair_bits;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic [35:0] diff;
  logic        ge;

  // upper 16 pairs come from mag2, the low half is zero
  if (PAIR >= 16) begin : g_hi
    assign pair_bits = info_i.mag2[2*(PAIR-16)+1 -: 2];
  end else begin : g_lo
    assign pair_bits = 2'b00;
  end

  always_comb begin
    rem_sh   = {rem_i, pair_bits};
    trial    = {2'b00, root_i, 2'b01};
    diff     = rem_sh - trial;
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? diff[33:0] : rem_sh[33:0];
    root_nxt = {root_i[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      info_r.vld <= 1'b0;
    end else if (en) begin
      info_r <= info_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign info_o = info_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

>>> rtl/core/aarm_div_cell.sv
// One restoring quotient bit for the three axis normalization divides.
`timescale 1ns / 1ps

module aarm_div_cell #(
  parameter int FRAC_BITS = 14,
  parameter int BIT       = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  aarm_pkg::axis_info_t info_i,
  input  logic [31:0]          len_i,
  input  logic [FRAC_BITS+32:0] rem_i [3],
  input  logic [FRAC_BITS:0]   q_i [3],
  output aarm_pkg::axis_info_t info_o,
  output logic [31:0]          len_o,
  output logic [FRAC_BITS+32:0] rem_o [3],
  output logic [FRAC_BITS:0]   q_o [3]
);

  localparam int NW = FRAC_BITS + 33;
  localparam int QW = FRAC_BITS + 1;

  aarm_pkg::axis_info_t info_r;
  logic [31:0]  len_r;
  logic [NW-1:0] rem_r [3];
  logic [NW-1:0] rem_nxt [3];
  logic [QW-1:0] q_r [3];
  logic [QW-1:0] q_nxt [3];
  logic [NW-1:0] cand;

  // compare against the divisor scaled to this bit
  always_comb begin
    cand = NW'(len_i) << BIT;
    for (int a = 0; a < 3; a++) begin
      if (rem_i[a] >= cand) begin
        rem_nxt[a] = rem_i[a] - cand;
        q_nxt[a]   = q_i[a] | (QW'(1) << BIT);
      end else begin
        rem_nxt[a] = rem_i[a];
        q_nxt[a]   = q_i[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      info_r.vld <= 1'b0;
    end else if (en) begin
      info_r <= info_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_r <= len_i;
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign info_o = info_r;
  assign len_o  = len_r;
  assign rem_o  = rem_r;
  assign q_o    = q_r;

endmodule

>>> tb/aarm_checker.sv
// Checker for the rotation matrix unit: predicts each matrix and compares it with the output.
`timescale 1ns / 1ps

module aarm_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [15:0]  cfg_wdata,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [79:0]  in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [143:0] out_tdata,
  input  logic         out_tuser,
  output int           n_fail,
  output int           n_pending,
  output int           n_matrices,
  output int           n_zero_axis,
  output int           n_normalized
);

  localparam int CORDIC_STEPS = 16;
  localparam int FRACB        = 14;

  typedef struct {
    logic [143:0] mat;
    logic         zero;
  } matrix_t;

  matrix_t    matrix_q[$];
  logic [15:0] tol_reg;

  function automatic longint fshift(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint rshift(longint v, int k);
    if (k == 0) return v;
    return (v + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint unit_comp(longint v, logic norm, longint unsigned len30);
    longint unsigned mag, q;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    if (norm) q = ((mag << (FRACB + 16)) + (len30 >> 1)) / len30;
    else q = mag << (FRACB - 14);
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint mulq(longint a, longint b);
    return rshift(a * b, FRACB);
  endfunction

  function automatic logic [15:0] to_q14(longint q30);
    longint r;
    r = rshift(q30, 16);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  // Rodrigues matrix for one input word
  function automatic matrix_t predict_matrix(logic [79:0] d, logic [15:0] tol, output logic nrm);
    matrix_t res;
    longint ax, ay, az, ang, r, theta, cx, cy, cz, c, s, t, ux, uy, uz, dx, dy, dev;
    longint xx, yy, zz, xy, xz, yz;
    longint m[9];
    longint unsigned mag2, len30;
    logic neg_s, neg_c;
    longint atan_tab[32] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
      65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
      15, 7, 3, 1, 0, 0};
    ax = longint'($signed(d[15:0]));
    ay = longint'($signed(d[31:16]));
    az = longint'($signed(d[47:32]));
    ang = longint'($signed(d[79:48]));
    nrm = 1'b0;
    mag2 = ax * ax + ay * ay + az * az;
    if (mag2 == 0) begin
      res.mat = '0;
      res.mat[15:0] = 16'd16384;
      res.mat[79:64] = 16'd16384;
      res.mat[143:128] = 16'd16384;
      res.zero = 1'b1;
      return res;
    end
    neg_s = 0;
    neg_c = 0;
    r = ang % 23592960;
    if (r < 0) r += 23592960;
    if (r <= 5898240) theta = r;
    else if (r <= 11796480) begin theta = 11796480 - r; neg_c = 1; end
    else if (r <= 17694720) begin theta = r - 11796480; neg_s = 1; neg_c = 1; end
    else begin theta = 23592960 - r; neg_s = 1; end
    cz = (theta * 74961321 + (longint'(1) << 17)) >>> 18;
    cx = 652032874;
    cy = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = fshift(cy, i);
      dy = fshift(cx, i);
      if (cz >= 0) begin
        cx -= dx; cy += dy; cz -= atan_tab[i];
      end else begin
        cx += dx; cy -= dy; cz += atan_tab[i];
      end
    end
    c = neg_c ? -cx : cx;
    s = neg_s ? -cy : cy;
    t = (longint'(1) << 30) - c;
    dev = longint'(mag2) - (longint'(1) << 28);
    if (dev < 0) dev = -dev;
    nrm = dev > longint'(tol);
    len30 = nrm ? int_sqrt(mag2 << 32) : 64'd0;
    ux = unit_comp(ax, nrm, len30);
    uy = unit_comp(ay, nrm, len30);
    uz = unit_comp(az, nrm, len30);
    xx = mulq(ux, ux); yy = mulq(uy, uy); zz = mulq(uz, uz);
    xy = mulq(ux, uy); xz = mulq(ux, uz); yz = mulq(uy, uz);
    m[0] = mulq(t, xx) + c;
    m[1] = mulq(t, xy) + mulq(s, uz);
    m[2] = mulq(t, xz) - mulq(s, uy);
    m[3] = mulq(t, xy) - mulq(s, uz);
    m[4] = mulq(t, yy) + c;
    m[5] = mulq(t, yz) + mulq(s, ux);
    m[6] = mulq(t, xz) + mulq(s, uy);
    m[7] = mulq(t, yz) - mulq(s, ux);
    m[8] = mulq(t, zz) + c;
    for (int k = 0; k < 9; k++) res.mat[16*k +: 16] = to_q14(m[k]);
    res.zero = 1'b0;
    return res;
  endfunction

  assign n_pending = matrix_q.size();

  // Track register, predict on input words, compare on output words
  always @(posedge clk) begin
    matrix_t exp_m;
    logic nrm;
    if (!rst_n) begin
      tol_reg <= aarm_pkg::TOL_RESET;
    end else begin
      if (cfg_valid && cfg_ready) tol_reg <= cfg_wdata;
      if (in_tvalid && in_tready) begin
        exp_m = predict_matrix(in_tdata, tol_reg, nrm);
        matrix_q.push_back(exp_m);
        if (exp_m.zero) n_zero_axis++;
        if (nrm) n_normalized++;
      end
      if (out_tvalid && out_tready) begin
        n_matrices++;
        if (matrix_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) $display("unexpected output word %h zero=%b", out_tdata, out_tuser);
        end else begin
          exp_m = matrix_q.pop_front();
          for (int k = 0; k < 9; k++) begin
            if (out_tdata[16*k +: 16] !== exp_m.mat[16*k +: 16]) begin
              n_fail++;
              if (n_fail <= 10)
                $display("entry %0d: expected %0d got %0d", k,
                         $signed(exp_m.mat[16*k +: 16]), $signed(out_tdata[16*k +: 16]));
            end
          end
          if (out_tuser !== exp_m.zero) begin
            n_fail++;
            if (n_fail <= 10)
              $display("zero_axis: expected %b got %b", exp_m.zero, out_tuser);
          end
        end
      end
    end
  end

endmodule

>>> tb/testbench.sv
// Testbench top: stimulus, idle phases, configuration and verdict for the rotation matrix unit.
`timescale 1ns / 1ps

module testbench;

  localparam int LATENCY   = 43 + 14;
  localparam int MAX_CYCLE = 400000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [15:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [79:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;
  logic         out_tuser;
  int           n_fail, n_pending, n_matrices, n_zero_axis, n_normalized;
  int           cycle = 0;
  int           send_idle = 0;
  int           recv_stall = 0;
  int           n_sent = 0;

  axis_angle_rotation_matrix_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  aarm_checker i_chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .n_fail(n_fail), .n_pending(n_pending), .n_matrices(n_matrices),
    .n_zero_axis(n_zero_axis), .n_normalized(n_normalized)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall);
  end

  // valid stays high between back-to-back words; it drops only on idle cycles and while draining
  task automatic send_word(input logic [15:0] x, y, z, input logic [31:0] ang);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata <= {ang, z, y, x};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    n_sent++;
  endtask

  task automatic drain_pipe();
    in_tvalid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic write_tol(input logic [15:0] v);
    drain_pipe();
    cfg_wdata <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Axis near unit length, with small jitter so tolerance matters
  task automatic send_unitish();
    logic [15:0] x, y, z;
    int sel;
    sel = $urandom_range(5);
    x = 16'd0; y = 16'd0; z = 16'd0;
    case (sel)
      0: x = 16'sd16384;
      1: y = -16'sd16384;
      2: z = 16'sd16384;
      3: begin x = 16'sd9459; y = 16'sd9459; z = 16'sd9459; end
      4: begin x = 16'sd11585; y = -16'sd11585; end
      default: begin y = 16'sd11585; z = 16'sd11585; end
    endcase
    x = 16'(x + $urandom_range(4) - 2);
    send_word(x, y, z, $urandom);
  endtask

  task automatic send_random();
    logic [31:0] ang;
    int kind;
    kind = $urandom_range(9);
    ang = (kind < 4) ? $urandom : ($urandom_range(720 * 4) - 360 * 4) << 14;
    if (kind == 9) send_word(16'd0, 16'd0, 16'd0, ang);
    else if (kind < 3) send_unitish();
    else send_word(16'($urandom), 16'($urandom), 16'($urandom), ang);
  endtask

  task automatic run_phase(input int idle, input int stall, input int count);
    send_idle = idle;
    recv_stall = stall;
    repeat (count) send_random();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, quadrant edges, zero axis, exact unit axes
    send_word(16'd0, 16'd0, 16'd0, 32'h0);
    send_word(16'd0, 16'd0, 16'd0, 32'h7fffffff);
    send_word(16'sd16384, 16'd0, 16'd0, 32'd90 << 16);
    send_word(16'd0, 16'sd16384, 16'd0, 32'd180 << 16);
    send_word(16'd0, 16'd0, 16'sd16384, 32'd270 << 16);
    send_word(16'sd16384, 16'd0, 16'd0, 32'd360 << 16);
    send_word(16'd0, 16'sd16384, 16'd0, -(32'd90 << 16));
    send_word(16'h7fff, 16'h7fff, 16'h7fff, 32'h80000000);
    send_word(16'h8000, 16'h8000, 16'h8000, 32'h7fffffff);
    send_word(16'h8000, 16'd0, 16'h7fff, 32'hffffffff);
    send_word(16'd1, 16'd0, 16'd0, 32'd45 << 16);
    send_word(16'd0, 16'hffff, 16'd0, 32'd135 << 16);
    send_word(16'sd9459, 16'sd9459, 16'sd9459, 32'd120 << 16);
    send_word(16'sd16385, 16'd0, 16'd0, 32'd30 << 16);
    send_word(16'hffff, 16'hffff, 16'hffff, 32'd1);
    send_word(16'h5555, 16'haaaa, 16'h5555, 32'haaaaaaaa);
    send_word(16'haaaa, 16'h5555, 16'haaaa, 32'h55555555);

    // Random phases under several tolerance settings
    run_phase(0, 0, 300);
    write_tol(16'd0);
    run_phase(55, 0, 300);
    // hold off until the pipe is empty
    drain_pipe();
    write_tol(16'hffff);
    run_phase(0, 55, 300);
    write_tol(16'd1000);
    run_phase(36, 36, 300);
    write_tol(16'd32);
    run_phase(0, 0, 215);
    run_phase(55, 55, 215);

    send_idle = 0;
    recv_stall = 0;
    drain_pipe();
    $display("Sent %0d words, checked %0d matrices (%0d zero axis, %0d normalized)",
             n_sent, n_matrices, n_zero_axis, n_normalized);
    $display("Tolerance settings 0, 32, 1000, 65535; idle and stall phases covered");
    if (n_fail == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

>>> filelist.f
rtl/core/aarm_pkg.sv
rtl/core/aarm_cordic_cell.sv
rtl/core/aarm_sqrt_cell.sv
rtl/core/aarm_div_cell.sv
rtl/core/axis_angle_rotation_matrix_unit.sv
tb/aarm_checker.sv
tb/testbench.sv
